// ===== sv/psr_pkg.sv =====
// Shared types and constants for the pie sector rasterizer.
// No dependencies; imported by every module of the block.
package psr_pkg;

  localparam int COORD_W     = 8;
  localparam int CORD_W      = 18;
  localparam int ANG_W       = 16;
  localparam int NUM_STEPS   = 15;
  localparam int STEP_W      = 4;
  localparam int NUM_VALUES  = 5;
  localparam int VAL_W       = 16;
  localparam int CUM_W       = 19;
  localparam int PROD_W      = ANG_W + CUM_W;
  localparam int RAD_W       = 7;
  localparam int CNT_W       = 3;
  localparam int SECTOR_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_RADIUS  = 64;

  localparam logic [RAD_W-1:0] RADIUS_RST = 7'd10;
  localparam logic [CNT_W-1:0] COUNT_RST  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_D  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_E  = 3'd6;

  localparam logic [ANG_W-1:0] ANG_ZERO = 16'd0;
  localparam logic [ANG_W-1:0] ANG_QTR  = 16'd16384;
  localparam logic [ANG_W-1:0] ANG_HALF = 16'd32768;
  localparam logic [ANG_W-1:0] ANG_3QTR = 16'd49152;

  localparam logic [SECTOR_W-1:0] SECTOR_FIRST = 3'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_LAST  = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } in_t;

  typedef struct packed {
    logic                inside_res;
    logic [SECTOR_W-1:0] sector;
  } out_t;

  typedef struct packed {
    logic                     in_circ;
    logic                     byp;
    logic signed [CORD_W-1:0] cx;
    logic signed [CORD_W-1:0] cy;
    logic [ANG_W-1:0]         z;
  } cell_t;

  typedef logic [NUM_VALUES-1:0][CUM_W-1:0] cum_t;

  function automatic logic [ANG_W-1:0] cordic_angle(input logic [STEP_W-1:0] step);
    logic [ANG_W-1:0] ang;
    case (step)
      4'd0:    ang = 16'd8192;
      4'd1:    ang = 16'd4836;
      4'd2:    ang = 16'd2555;
      4'd3:    ang = 16'd1297;
      4'd4:    ang = 16'd651;
      4'd5:    ang = 16'd326;
      4'd6:    ang = 16'd163;
      4'd7:    ang = 16'd81;
      4'd8:    ang = 16'd41;
      4'd9:    ang = 16'd20;
      4'd10:   ang = 16'd10;
      4'd11:   ang = 16'd5;
      4'd12:   ang = 16'd3;
      4'd13:   ang = 16'd1;
      4'd14:   ang = 16'd1;
      default: ang = 16'd0;
    endcase
    return ang;
  endfunction

endpackage

// ===== sv/psr_cordic_cell.sv =====
// One CORDIC rotation cell with its own stage register and handshake.
// Depends on psr_pkg.
module psr_cordic_cell import psr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step,
  input  logic              in_valid,
  output logic              in_ready,
  input  cell_t             in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cell_t             out_data
);

  logic                     vld_r;
  cell_t                    dat_r;
  cell_t                    dat_nxt;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic                     y_pos;

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = dat_r;

  always_comb begin
    dx      = in_data.cy >>> step;
    dy      = in_data.cx >>> step;
    y_pos   = !in_data.cy[CORD_W-1] && (in_data.cy != '0);
    dat_nxt = in_data;
    if (!in_data.byp) begin
      if (y_pos) begin
        dat_nxt.cx = in_data.cx + dx;
        dat_nxt.cy = in_data.cy - dy;
        dat_nxt.z  = in_data.z + cordic_angle(step);
      end else begin
        dat_nxt.cx = in_data.cx - dx;
        dat_nxt.cy = in_data.cy + dy;
        dat_nxt.z  = in_data.z - cordic_angle(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

// ===== sv/psr_sector.sv =====
// Sector select and output register: angle times total against each cumulative share.
// Depends on psr_pkg.
module psr_sector import psr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cum_t  cum,
  input  logic  in_valid,
  output logic  in_ready,
  input  cell_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic              vld_r;
  out_t              dat_r;
  out_t              dat_nxt;
  logic [PROD_W-1:0] prod;

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = dat_r;

  always_comb begin
    prod = in_data.z * cum[NUM_VALUES-1];
    dat_nxt.inside_res = in_data.in_circ;
    dat_nxt.sector     = SECTOR_LAST;
    if (cum[NUM_VALUES-1] != '0) begin
      for (int k = NUM_VALUES - 2; k >= 0; k--) begin
        if (prod <= {cum[k], ANG_W'(0)}) begin
          dat_nxt.sector = SECTOR_W'(k);
        end
      end
    end
    if (!in_data.in_circ) begin
      dat_nxt.sector = SECTOR_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

// ===== sv/pie_sector_rasterizer.sv =====
// Pie sector rasterizer top: config registers, entry stage, CORDIC cell chain, sector stage.
// Stages in order: entry stage, 15 CORDIC cells, sector stage, each with its own register.
// Throughput: one beat per cycle when out_ready is high, set by the one-stage-per-cell chain.
// Each stage holds its beat under backpressure and bubbles collapse.
// Reset (rst_n, synchronous): pipeline emptied, radius 10, count 5, values 0.
// Cumulative shares are registered and settle in the cycle after a config write lands.
module pie_sector_rasterizer import psr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [RAD_W-1:0]                   rad_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [NUM_VALUES-1:0][VAL_W-1:0]   val_r;
  cum_t                               cum_r;
  cum_t                               cum_nxt;

  logic [NUM_STEPS:0]                 stg_vld;
  logic [NUM_STEPS:0]                 stg_rdy;
  cell_t [NUM_STEPS:0]                stg_dat;

  logic                               ent_vld_r;
  cell_t                              ent_dat_r;
  cell_t                              ent_nxt;
  logic signed [2*COORD_W-1:0]        sq_x;
  logic signed [2*COORD_W-1:0]        sq_y;
  logic [CUM_W-1:0]                   lhs;
  logic [RAD_W-1:0]                   r_sat;
  logic [2*RAD_W-2:0]                 r2;
  logic [CUM_W-1:0]                   rhs;
  logic signed [CORD_W-1:0]           xv;
  logic signed [CORD_W-1:0]           yv;
  logic signed [CORD_W-1:0]           yv3;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RADIUS_RST;
      cnt_r <= COUNT_RST;
      val_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: rad_r    <= cfg_wdata[RAD_W-1:0];
        CFG_COUNT:  cnt_r    <= cfg_wdata[CNT_W-1:0];
        CFG_VAL_A:  val_r[0] <= cfg_wdata[VAL_W-1:0];
        CFG_VAL_B:  val_r[1] <= cfg_wdata[VAL_W-1:0];
        CFG_VAL_C:  val_r[2] <= cfg_wdata[VAL_W-1:0];
        CFG_VAL_D:  val_r[3] <= cfg_wdata[VAL_W-1:0];
        CFG_VAL_E:  val_r[4] <= cfg_wdata[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0] n_sat;
    logic [CUM_W-1:0] acc;
    n_sat = (cnt_r > CNT_W'(NUM_VALUES)) ? CNT_W'(NUM_VALUES) : cnt_r;
    acc   = '0;
    for (int j = 0; j < NUM_VALUES; j++) begin
      if (CNT_W'(j) < n_sat) begin
        acc = acc + CUM_W'(val_r[j]);
      end
      cum_nxt[j] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cum_r <= '0;
    end else begin
      cum_r <= cum_nxt;
    end
  end

  // entry stage: circle test and CORDIC seed
  always_comb begin
    sq_x  = in_data.pos_x * in_data.pos_x;
    sq_y  = in_data.pos_y * in_data.pos_y;
    lhs   = {2'b00, sq_x[2*COORD_W-2:0], 2'b00}
          + CUM_W'({sq_y[2*COORD_W-2:0], 3'b000}) + CUM_W'(sq_y[2*COORD_W-2:0]);
    r_sat = (rad_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_r;
    r2    = r_sat * r_sat;
    rhs   = CUM_W'({r2, 3'b000}) + CUM_W'(r2);
    xv    = CORD_W'(in_data.pos_x);
    yv    = CORD_W'(in_data.pos_y);
    yv3   = (yv <<< 1) + yv;

    ent_nxt.in_circ = (lhs <= rhs);
    ent_nxt.byp     = (in_data.pos_x == '0) || (in_data.pos_y == '0);
    ent_nxt.cx      = yv3 <<< 6;
    ent_nxt.cy      = xv <<< 7;
    ent_nxt.z       = ANG_ZERO;
    if (in_data.pos_x == '0) begin
      ent_nxt.z = in_data.pos_y[COORD_W-1] ? ANG_HALF : ANG_ZERO;
    end else if (in_data.pos_y == '0) begin
      ent_nxt.z = in_data.pos_x[COORD_W-1] ? ANG_3QTR : ANG_QTR;
    end else if (in_data.pos_y[COORD_W-1]) begin
      ent_nxt.cx = -(yv3 <<< 6);
      ent_nxt.cy = -(xv <<< 7);
      ent_nxt.z  = ANG_HALF;
    end
  end

  assign in_ready   = !ent_vld_r || stg_rdy[0];
  assign stg_vld[0] = ent_vld_r;
  assign stg_dat[0] = ent_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (in_ready) begin
      ent_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent_dat_r <= ent_nxt;
    end
  end

  // CORDIC chain
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    psr_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (STEP_W'(i)),
      .in_valid  (stg_vld[i]),
      .in_ready  (stg_rdy[i]),
      .in_data   (stg_dat[i]),
      .out_valid (stg_vld[i+1]),
      .out_ready (stg_rdy[i+1]),
      .out_data  (stg_dat[i+1])
    );
  end

  psr_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .cum       (cum_r),
    .in_valid  (stg_vld[NUM_STEPS]),
    .in_ready  (stg_rdy[NUM_STEPS]),
    .in_data   (stg_dat[NUM_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_outside_sector0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |-> out_data.sector == SECTOR_FIRST)
    else $error("outside beat with nonzero sector");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sector <= SECTOR_LAST)
    else $error("sector out of range");

  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res && cum_r[NUM_VALUES-1] == '0
    |-> out_data.sector == SECTOR_LAST)
    else $error("zero total must give last sector");

  a_center_inside: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.pos_x == '0 && in_data.pos_y == '0
    |=> ent_vld_r && ent_dat_r.in_circ && ent_dat_r.byp)
    else $error("center beat not marked inside");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for pie_sector_rasterizer: a directed table, then random pixels
// over several register settings, each beat compared with a local pixel classifier or a known table result.
// Depends on psr_pkg (sv/psr_pkg.sv) and the block's top level.
`timescale 1ns / 1ps

module testbench;
  import psr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int LONG_HOLD  = 200;
  localparam int PHASE_PIX  = 100;
  localparam int NUM_PHASES = 11;
  localparam int DRAIN_CYC  = 40;
  localparam int N_ROWS     = 36;

  typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_PIX_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                     in_circ;
    logic [SECTOR_W-1:0]      sector;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [RAD_W-1:0] cur_radius;
  logic [CNT_W-1:0] cur_count;
  logic [VAL_W-1:0] cur_vals [NUM_VALUES];

  out_t class_q [$];
  int   err_count   = 0;
  int   snd_idle    = 0;
  int   rcv_idle    = 0;
  int   stall_reqs  = 0;
  int   stall_done  = 0;

  int turn_step [0:14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

  row_t script [0:N_ROWS-1] = '{
    // reset settings: radius 10, all values zero
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,    8'sd0,    8'sd0,    1'b1, SECTOR_LAST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,    8'sd0,    8'sd10,   1'b1, SECTOR_LAST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,    8'sd0,    8'sd11,   1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,    8'sd15,   8'sd0,    1'b1, SECTOR_LAST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,   -8'sd16,   8'sd0,    1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,    8'sd127,  8'sd127,  1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0,   -8'sd128, -8'sd128,  1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_RADIUS, 16'd64,   8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_VAL_A,  16'd1000, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_VAL_B,  16'd2000, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_VAL_C,  16'd3000, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_VAL_D,  16'd4000, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_VAL_E,  16'd5000, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_REG, CFG_SPARE,  16'hFFFF, 8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    // axes, quadrants and the rim
    '{ROW_PIX, 3'd0, 16'd0,   8'sd0,    8'sd5,   1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd0,   -8'sd5,   1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd5,    8'sd0,   1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd5,    8'sd0,   1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd20,   8'sd20,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd20,  -8'sd20,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd20,  -8'sd20,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd20,   8'sd20,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd1,    8'sd60,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd96,   8'sd0,   1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd0,    8'sd64,  1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd0,   -8'sd64,  1'b0, SECTOR_FIRST},
    // count above five
    '{ROW_REG, CFG_COUNT,  16'd7,    8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,  -8'sd20,   8'sd20,  1'b0, SECTOR_FIRST},
    // radius 0: center only
    '{ROW_REG, CFG_RADIUS, 16'd0,    8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd0,    8'sd0,   1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0, 8'sd1, 8'sd0,   1'b0, SECTOR_FIRST},
    // radius saturates at the maximum
    '{ROW_REG, CFG_RADIUS, 16'd127,  8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_PIX, 3'd0, 16'd0,   8'sd96,   8'sd0,   1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0, 8'sd97, 8'sd0,  1'b0, SECTOR_FIRST},
    // zero total
    '{ROW_REG, CFG_COUNT,  16'd0,    8'sd0, 8'sd0, 1'b0, SECTOR_FIRST},
    '{ROW_PIX_KNOWN, 3'd0, 16'd0, 8'sd3, 8'sd3,   1'b1, SECTOR_LAST}
  };

  pie_sector_rasterizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pie_angle(int u, int v);
    int cx, cy, ang, dx, dy, i;
    if (u == 0) return (v >= 0) ? int'(ANG_ZERO) : int'(ANG_HALF);
    if (v == 0) return (u > 0) ? int'(ANG_QTR) : int'(ANG_3QTR);
    cx  = v * 64;
    cy  = u * 64;
    ang = 0;
    if (cx < 0) begin
      cx  = -cx;
      cy  = -cy;
      ang = int'(ANG_HALF);
    end
    for (i = 0; i < NUM_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        ang = ang + turn_step[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        ang = ang - turn_step[i];
      end
    end
    return ang & 32'hFFFF;
  endfunction

  function automatic out_t classify_pixel(in_t px);
    out_t   res;
    int     x, y, r, n, k, ang;
    longint lhs, rhs, total;
    longint cum [NUM_VALUES];
    bit     found;
    x = $signed(px.pos_x);
    y = $signed(px.pos_y);
    r = (cur_radius > MAX_RADIUS) ? MAX_RADIUS : int'(cur_radius);
    n = (cur_count > NUM_VALUES) ? NUM_VALUES : int'(cur_count);
    lhs = 4 * x * x + 9 * y * y;
    rhs = 9 * r * r;
    res.inside_res = 1'b0;
    res.sector     = SECTOR_FIRST;
    if (lhs > rhs) return res;
    total = 0;
    for (k = 0; k < NUM_VALUES; k++) begin
      if (k < n) total += cur_vals[k];
      cum[k] = total;
    end
    res.inside_res = 1'b1;
    res.sector     = SECTOR_LAST;
    if (total != 0) begin
      ang   = pie_angle(2 * x, 3 * y);
      found = 1'b0;
      for (k = 0; k < 4; k++) begin
        if (!found && longint'(ang) * total <= 64'd65536 * cum[k]) begin
          res.sector = SECTOR_W'(k);
          found      = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // entered and left at a rising edge
  task automatic send_pixel(in_t px, bit known, out_t want);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    class_q.push_back(known ? want : classify_pixel(px));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_RADIUS: cur_radius = data[RAD_W-1:0];
      CFG_COUNT:  cur_count  = data[CNT_W-1:0];
      CFG_VAL_A, CFG_VAL_B, CFG_VAL_C, CFG_VAL_D, CFG_VAL_E:
        cur_vals[idx - CFG_VAL_A] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (class_q.size() != 0);
    @(posedge clk);
  endtask

  // result side: random stalls plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_done) begin
        stall_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (class_q.size() == 0) begin
        flag_mismatch("unexpected beat, inside_res", out_data.inside_res, -1);
      end else begin
        want = class_q.pop_front();
        if (out_data.inside_res !== want.inside_res)
          flag_mismatch("inside_res", out_data.inside_res, want.inside_res);
        if (out_data.sector !== want.sector)
          flag_mismatch("sector", out_data.sector, want.sector);
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_t              px;
    logic [15:0]      d;
    int               p, i, j, r_eff, xs, ys, xv, yv;
    logic [RAD_W-1:0] rad;
    logic [CNT_W-1:0] cnt;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_radius = RADIUS_RST;
    cur_count  = COUNT_RST;
    for (i = 0; i < NUM_VALUES; i++) cur_vals[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 32;
    rcv_idle = 54;
    for (i = 0; i < N_ROWS; i++) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        px.pos_x = script[i].x;
        px.pos_y = script[i].y;
        send_pixel(px, script[i].kind == ROW_PIX_KNOWN,
                   '{inside_res: script[i].in_circ, sector: script[i].sector});
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       begin rad = 7'd64;  cnt = 3'd5; end
        1:       begin rad = 7'd127; cnt = 3'd7; end
        2:       begin rad = 7'd0;   cnt = 3'd0; end
        3:       begin rad = 7'd1;   cnt = 3'd6; end
        4:       begin rad = 7'd64;  cnt = 3'd1; end
        default: begin rad = RAD_W'($urandom_range(1, 100)); cnt = CNT_W'($urandom); end
      endcase
      d = 16'($urandom);
      d[RAD_W-1:0] = rad;
      write_reg(CFG_RADIUS, d);
      d = 16'($urandom);
      d[CNT_W-1:0] = cnt;
      write_reg(CFG_COUNT, d);
      for (j = 0; j < NUM_VALUES; j++) begin
        case (p == 0 ? 1 : $urandom_range(3))
          0:       d = '0;
          1:       d = 16'hFFFF;
          default: d = 16'($urandom);
        endcase
        write_reg(CFG_VAL_A + CFG_IDX_W'(j), d);
      end
      if (p % 3 == 0) write_reg(CFG_SPARE, 16'($urandom));

      if (p < 4) begin
        snd_idle = 32;
        rcv_idle = 54;
      end else if (p < 8) begin
        snd_idle = 54;
        rcv_idle = 32;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (p == 1 || p == 6) stall_reqs++;

      r_eff = (rad > MAX_RADIUS) ? MAX_RADIUS : int'(rad);
      xs = (3 * r_eff) / 2 + 2;
      ys = r_eff + 2;
      for (i = 0; i < PHASE_PIX; i++) begin
        if ($urandom_range(99) < 70) begin
          xv = int'($urandom_range(0, 2 * xs)) - xs;
          yv = int'($urandom_range(0, 2 * ys)) - ys;
          if (xv > 127) xv = 127;
          if (xv < -128) xv = -128;
          px.pos_x = COORD_W'(xv);
          px.pos_y = COORD_W'(yv);
        end else begin
          px = in_t'(16'($urandom));
        end
        send_pixel(px, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
